// ----- hw/rtl/normalized_graph_laplacian_macros.svh -----
// Assertion helpers shared by the RTL modules.
`ifndef NORMALIZED_GRAPH_LAPLACIAN_MACROS_SVH
`define NORMALIZED_GRAPH_LAPLACIAN_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define NGL_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define NGL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/ngl_pkg.sv -----
package ngl_pkg;

    localparam logic signed [15:0] SAT_VALUE = 16'sh8000;
    localparam logic [5:0] DIV_DIAG_STEPS = 6'd16;
    localparam logic [5:0] DIV_OFF_STEPS  = 6'd34;
    localparam logic [5:0] SQRT_STEPS     = 6'd17;
    localparam logic       CMD_WRITE      = 1'b0;
    localparam logic       CMD_QUERY      = 1'b1;

    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_RD0   = 9'b000000100,
        S_RD1   = 9'b000001000,
        S_RD2   = 9'b000010000,
        S_MUL   = 9'b000100000,
        S_SETUP = 9'b001000000,
        S_DIV   = 9'b010000000,
        S_SQRT  = 9'b100000000
    } t_state;

    typedef struct packed {
        logic clr;
        logic load;
        logic rd_row;
        logic cap_row;
        logic cap_col;
        logic wr;
        logic mul;
        logic setup;
        logic div_step;
        logic sqrt_step;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic is_query;
        logic quick;
        logic diag;
        logic last;
    } t_sts;

endpackage

// ----- hw/rtl/normalized_graph_laplacian.sv -----
// A write reads the old weight and row degree, then writes back the new weight and degree;
// a query reads the weight and both degrees and multiplies, then settles a trivial case
// without the divider or runs the shared restoring divider (16 or 34 steps) and, off the
// diagonal, the 17-step square root. One beat at a time: a new beat is taken only after the
// last is done, and busy covers the result strobe.
// Reset: synchronous active low, then a clearing pass over both stores; o_valid lasts one cycle.
module normalized_graph_laplacian #(
    parameter int NODES = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_command,
    input  logic [5:0]         i_row,
    input  logic [5:0]         i_col,
    input  logic [15:0]        i_weight,
    output logic               o_valid,
    output logic signed [15:0] o_value,
    output logic               o_saturated
);
    import ngl_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // sequencer: clear pass, memory access order, iteration control
    ngl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // stores, degree update, divider and square root
    ngl_dp #(
        .NODES (NODES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_command   (i_command),
        .i_row       (i_row),
        .i_col       (i_col),
        .i_weight    (i_weight),
        .o_valid     (o_valid),
        .o_value     (o_value),
        .o_saturated (o_saturated)
    );
endmodule

// ----- hw/rtl/ngl_ctrl.sv -----
module ngl_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  ngl_pkg::t_sts i_sts,
    output ngl_pkg::t_cmd o_cmd
);
    import ngl_pkg::*;
    `include "normalized_graph_laplacian_macros.svh"

    t_state r_state;
    t_state n_state;
    logic   r_emit;

    assign busy = (r_state != S_IDLE) || r_emit;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (start && !r_emit) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RD0;
                end
            end
            S_RD0: begin
                o_cmd.rd_row = 1'b1;
                n_state      = S_RD1;
            end
            S_RD1: begin
                o_cmd.cap_row = 1'b1;
                n_state       = S_RD2;
            end
            S_RD2: begin
                if (i_sts.is_query) begin
                    o_cmd.cap_col = 1'b1;
                    n_state       = S_MUL;
                end else begin
                    o_cmd.wr = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_SETUP;
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                if (i_sts.quick) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.last) begin
                    if (i_sts.diag) begin
                        o_cmd.emit = 1'b1;
                        n_state    = S_IDLE;
                    end else begin
                        n_state = S_SQRT;
                    end
                end
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (i_sts.last) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_emit  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_emit  <= o_cmd.emit;
        end
    end

    `NGL_ASSERT_NEXT(a_div_holds, i_clk, i_rst_n, (r_state == S_DIV) && !i_sts.last, r_state == S_DIV, "divider left early")
    `NGL_ASSERT_NEXT(a_clear_no_accept, i_clk, i_rst_n, r_state == S_CLEAR, (r_state == S_CLEAR) || (r_state == S_IDLE), "clear pass interrupted")
endmodule

// ----- hw/rtl/ngl_dp.sv -----
module ngl_dp #(
    parameter int NODES = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ngl_pkg::t_cmd       i_cmd,
    output ngl_pkg::t_sts       o_sts,
    input  logic                i_command,
    input  logic [5:0]          i_row,
    input  logic [5:0]          i_col,
    input  logic [15:0]         i_weight,
    output logic                o_valid,
    output logic signed [15:0]  o_value,
    output logic                o_saturated
);
    import ngl_pkg::*;
    `include "normalized_graph_laplacian_macros.svh"

    localparam int AW  = $clog2(NODES * NODES);
    localparam int NIW = $clog2(NODES);
    localparam int DW  = 16 + $clog2(NODES);
    localparam int PW  = 2 * DW;
    localparam int RW  = PW + 1;
    localparam int NW  = DW + 16;
    localparam logic [AW-1:0] LAST_ADDR = AW'(NODES * NODES - 1);

    logic [15:0]   wmem [NODES*NODES];
    logic [DW-1:0] dmem [NODES];

    logic [AW-1:0] r_clr;
    logic          r_cmd;
    logic [5:0]    r_row, r_col;
    logic [15:0]   r_wt;
    logic [15:0]   r_wq;
    logic [DW-1:0] r_dq;
    logic [15:0]   r_w;
    logic [DW-1:0] r_di, r_dj;
    logic [PW-1:0] r_p;
    logic [31:0]   r_w2;
    logic [RW-1:0] r_rem, r_div, n_rem, t_div;
    logic [33:0]   r_sh, r_q, n_q;
    logic [5:0]    r_cnt;
    logic [33:0]   r_rad;
    logic [16:0]   r_root, n_root;
    logic [19:0]   r_srem, n_srem, t_sq, trial;
    logic          r_valid, r_sat;
    logic signed [15:0] r_value;

    logic          idx_ok, diag, ge_div, ge_sq;
    logic [AW-1:0] waddr;
    logic [NW-1:0] diag_num;
    logic [16:0]   k_mag, k_neg;
    logic          quick;
    logic signed [15:0] quick_value;
    logic          quick_sat;

    assign idx_ok = (32'(r_row) < 32'(NODES)) && (32'(r_col) < 32'(NODES));
    assign diag   = (r_row == r_col);
    assign waddr  = AW'(32'(r_row) * NODES + 32'(r_col));

    // special results resolved without the divider
    always_comb begin
        quick       = 1'b1;
        quick_value = '0;
        quick_sat   = 1'b0;
        if (!idx_ok) begin
            quick = 1'b1;
        end else if (diag) begin
            quick = (r_di == '0) || (DW'(r_w) > r_di);
        end else if (r_w == '0) begin
            quick = 1'b1;
        end else if ((r_p == '0) || (RW'(r_w2[31:4]) >= RW'(r_p))) begin
            quick_value = SAT_VALUE;
            quick_sat   = 1'b1;
        end else begin
            quick = 1'b0;
        end
    end

    assign o_sts.clr_done = (r_clr == LAST_ADDR);
    assign o_sts.is_query = (r_cmd == CMD_QUERY);
    assign o_sts.quick    = quick;
    assign o_sts.diag     = diag;
    assign o_sts.last     = (r_cnt == 6'd1);

    assign diag_num = (NW'(r_di - DW'(r_w)) << 15) + NW'(r_di);

    // one restoring divide step
    assign t_div  = {r_rem[RW-2:0], r_sh[33]};
    assign ge_div = (t_div >= r_div);
    assign n_rem  = ge_div ? t_div - r_div : t_div;
    assign n_q    = {r_q[32:0], ge_div};

    // one square root digit
    assign t_sq   = {r_srem[17:0], r_rad[33:32]};
    assign trial  = {1'b0, r_root, 2'b01};
    assign ge_sq  = (t_sq >= trial);
    assign n_srem = ge_sq ? t_sq - trial : t_sq;
    assign n_root = {r_root[15:0], ge_sq};
    assign k_mag  = 17'((18'(n_root) + 18'd1) >> 1);
    assign k_neg  = 17'd0 - k_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr   <= '0;
            r_valid <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_valid <= i_cmd.emit;
            if (i_cmd.clr && (r_clr != LAST_ADDR)) r_clr <= r_clr + 1'b1;
            if (i_cmd.setup) begin
                r_cnt <= diag ? DIV_DIAG_STEPS : DIV_OFF_STEPS;
            end else if (i_cmd.div_step) begin
                r_cnt <= (r_cnt == 6'd1) ? SQRT_STEPS : r_cnt - 6'd1;
            end else if (i_cmd.sqrt_step) begin
                r_cnt <= r_cnt - 6'd1;
            end
        end
    end

    // memories: clear sweep, write port, registered reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            wmem[r_clr] <= '0;
            if (32'(r_clr) < 32'(NODES)) dmem[NIW'(r_clr)] <= '0;
        end else if (i_cmd.wr && idx_ok) begin
            wmem[waddr]        <= r_wt;
            dmem[NIW'(r_row)]  <= r_di - DW'(r_w) + DW'(r_wt);
        end
        if (i_cmd.rd_row) begin
            r_wq <= wmem[waddr];
            r_dq <= dmem[NIW'(r_row)];
        end else if (i_cmd.cap_row) begin
            r_dq <= dmem[NIW'(r_col)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd <= i_command;
            r_row <= i_row;
            r_col <= i_col;
            r_wt  <= i_weight;
        end
        if (i_cmd.cap_row) begin
            r_w  <= r_wq;
            r_di <= r_dq;
        end
        if (i_cmd.cap_col) r_dj <= r_dq;
        if (i_cmd.mul) begin
            r_p  <= PW'(r_di) * PW'(r_dj);
            r_w2 <= 32'(r_w) * 32'(r_w);
        end
        if (i_cmd.setup) begin
            r_q <= '0;
            if (quick) begin
                r_value <= quick_value;
                r_sat   <= quick_sat;
            end else if (diag) begin
                r_rem <= RW'(diag_num[NW-1:16]);
                r_sh  <= {diag_num[15:0], 18'd0};
                r_div <= RW'({r_di, 1'b0});
            end else begin
                r_rem <= RW'(r_w2[31:4]);
                r_sh  <= {r_w2[3:0], 30'd0};
                r_div <= RW'(r_p);
            end
        end
        if (i_cmd.div_step) begin
            r_rem <= n_rem;
            r_q   <= n_q;
            r_sh  <= {r_sh[32:0], 1'b0};
            if (r_cnt == 6'd1) begin
                if (diag) begin
                    r_value <= signed'(n_q[15:0]);
                    r_sat   <= 1'b0;
                end else begin
                    r_rad  <= n_q;
                    r_root <= '0;
                    r_srem <= '0;
                end
            end
        end
        if (i_cmd.sqrt_step) begin
            r_rad  <= {r_rad[31:0], 2'b00};
            r_root <= n_root;
            r_srem <= n_srem;
            if (r_cnt == 6'd1) begin
                if (k_mag > 17'd32768) begin
                    r_value <= SAT_VALUE;
                    r_sat   <= 1'b1;
                end else begin
                    r_value <= signed'(k_neg[15:0]);
                    r_sat   <= 1'b0;
                end
            end
        end
    end

    assign o_valid     = r_valid;
    assign o_value     = r_value;
    assign o_saturated = r_sat;

    `NGL_ASSERT_IMPL(a_sat_value, i_clk, i_rst_n, r_valid && r_sat,
        r_value == SAT_VALUE, "saturated result not full scale")
    `NGL_ASSERT_IMPL(a_query_only, i_clk, i_rst_n, r_valid,
        r_cmd == CMD_QUERY, "result from a write")
    `NGL_ASSERT_IMPL(a_diag_sign, i_clk, i_rst_n, r_valid && diag && idx_ok,
        !r_value[15], "negative diagonal entry")
endmodule

// ----- test/normalized_graph_laplacian_test.sv -----
module normalized_graph_laplacian_test;
    import ngl_pkg::*;

    localparam int NODES        = 64;
    localparam int STALL_LIMIT  = 20000;  // covers the clearing pass after reset
    localparam int RANDOM_BEATS = 550;

    // Model of the stored graph: keeps its own copy of the weights and the row degrees,
    // and queues the Laplacian entry that each query beat is expected to return.
    class laplacian_scoreboard;
        logic [15:0]        edge_weight [NODES*NODES];
        logic [21:0]        row_degree [NODES];
        logic signed [15:0] entry_q [$];
        logic               clip_q [$];
        int                 mismatches;

        function new();
            foreach (edge_weight[k]) edge_weight[k] = '0;
            foreach (row_degree[k]) row_degree[k] = '0;
            mismatches = 0;
        endfunction

        // round(a / sqrt(p)) with ties up, found by bisection on the result
        function int unsigned scaled_inv_sqrt(longint unsigned a, longint unsigned p);
            longint unsigned x, m, m2;
            int unsigned lo, hi, k;
            x = 4 * a * a;
            lo = 0;
            hi = 32769;
            while (lo < hi) begin
                k = lo + (hi - lo + 1) / 2;
                m = 2 * longint'(k) - 1;
                m2 = m * m;
                if (p <= x / m2) lo = k;
                else hi = k - 1;
            end
            return lo;
        endfunction

        function void note_beat(logic cmd, logic [5:0] row, logic [5:0] col, logic [15:0] w_in);
            longint unsigned w, di, p;
            int unsigned mag;
            logic signed [15:0] entry;
            logic clip;
            int idx;
            idx = int'(row) * NODES + int'(col);
            if (cmd == CMD_WRITE) begin
                // move the row degree by the weight difference
                row_degree[row] = row_degree[row] - edge_weight[idx] + w_in;
                edge_weight[idx] = w_in;
                return;
            end
            entry = '0;
            clip = 1'b0;
            w = edge_weight[idx];
            di = row_degree[row];
            if (row == col) begin
                if (di != 0 && w <= di)
                    entry = 16'((2 * 16384 * (di - w) + di) / (2 * di));
            end else if (w != 0) begin
                p = di * row_degree[col];
                if (p == 0) begin
                    entry = SAT_VALUE;
                    clip = 1'b1;
                end else begin
                    mag = scaled_inv_sqrt(16384 * w, p);
                    if (mag > 32768) begin
                        entry = SAT_VALUE;
                        clip = 1'b1;
                    end else begin
                        entry = 16'(-mag);
                    end
                end
            end
            entry_q.push_back(entry);
            clip_q.push_back(clip);
        endfunction

        function void check_result(logic signed [15:0] value, logic sat);
            logic signed [15:0] exp_value;
            logic exp_sat;
            if (entry_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result value=%0d saturated=%b", value, sat);
                return;
            end
            exp_value = entry_q.pop_front();
            exp_sat = clip_q.pop_front();
            if (value !== exp_value || sat !== exp_sat) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result value=%0d saturated=%b, expected value=%0d saturated=%b",
                             value, sat, exp_value, exp_sat);
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               i_command;
    logic [5:0]         i_row;
    logic [5:0]         i_col;
    logic [15:0]        i_weight;
    logic               o_valid;
    logic signed [15:0] o_value;
    logic               o_saturated;

    laplacian_scoreboard graph_sb;
    int quiet_cycles;
    int burst_left;

    normalized_graph_laplacian #(.NODES(NODES)) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_command   (i_command),
        .i_row       (i_row),
        .i_col       (i_col),
        .i_weight    (i_weight),
        .o_valid     (o_valid),
        .o_value     (o_value),
        .o_saturated (o_saturated)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Check each result strobe; values seen here are those of the cycle that just ended.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            graph_sb.check_result(o_value, o_saturated);
            quiet_cycles <= 0;
        end
    end

    // Watchdog: count cycles without any accepted beat or result.
    always @(negedge i_clk) begin
        quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Present one beat from the falling edge; hold it until busy is low, so that the
    // next rising edge takes it. Then update the model.
    task automatic send_beat(logic cmd, logic [5:0] row, logic [5:0] col, logic [15:0] w);
        @(negedge i_clk);
        start = 1'b1;
        i_command = cmd;
        i_row = row;
        i_col = col;
        i_weight = w;
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        quiet_cycles = 0;
        graph_sb.note_beat(cmd, row, col, w);
        // drop start between bursts; random gaps let start rise again at varied points of the block's work
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            @(negedge i_clk);
            start = 1'b0;
            i_command = 1'($urandom);
            i_row = 6'($urandom);
            repeat ($urandom_range(0, 6)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
        end
    endtask

    function automatic logic [5:0] pick_node();
        // mostly a small group of nodes, so degrees build up and queries hit edges
        return ($urandom_range(0, 9) < 7) ? 6'($urandom_range(0, 5)) : 6'($urandom);
    endfunction

    function automatic logic [15:0] pick_weight();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(1, 255));
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        logic [5:0] a, b;
        graph_sb = new();
        quiet_cycles = 0;
        burst_left = 0;
        start = 1'b0;
        i_command = CMD_WRITE;
        i_row = '0;
        i_col = '0;
        i_weight = '0;
        i_rst_n = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Empty graph: diagonal with zero degree, off-diagonal with zero weight.
        send_beat(CMD_QUERY, 6'd0, 6'd0, 16'd0);
        send_beat(CMD_QUERY, 6'd63, 6'd0, 16'hFFFF);
        // One edge whose column node still has zero degree: saturates.
        send_beat(CMD_WRITE, 6'd0, 6'd1, 16'hFFFF);
        send_beat(CMD_QUERY, 6'd0, 6'd1, 16'd0);
        send_beat(CMD_QUERY, 6'd0, 6'd0, 16'd0);
        // Tiny column degree against a huge edge: magnitude above range, clipped.
        send_beat(CMD_WRITE, 6'd1, 6'd2, 16'd1);
        send_beat(CMD_QUERY, 6'd0, 6'd1, 16'd0);
        // Symmetric edge: ordinary off-diagonal entry, and a diagonal with self loop.
        send_beat(CMD_WRITE, 6'd1, 6'd0, 16'hFFFF);
        send_beat(CMD_WRITE, 6'd1, 6'd1, 16'h0080);
        send_beat(CMD_QUERY, 6'd0, 6'd1, 16'd0);
        send_beat(CMD_QUERY, 6'd1, 6'd0, 16'd0);
        send_beat(CMD_QUERY, 6'd1, 6'd1, 16'd0);
        // Highest indices, then overwrite a weight to move the degree back down.
        send_beat(CMD_WRITE, 6'd63, 6'd63, 16'h0100);
        send_beat(CMD_WRITE, 6'd63, 6'd62, 16'h0300);
        send_beat(CMD_QUERY, 6'd63, 6'd63, 16'd0);
        send_beat(CMD_WRITE, 6'd63, 6'd62, 16'd0);
        send_beat(CMD_QUERY, 6'd63, 6'd63, 16'd0);
        send_beat(CMD_QUERY, 6'd63, 6'd62, 16'd0);
        // Remove an edge; its query returns zero again.
        send_beat(CMD_WRITE, 6'd0, 6'd1, 16'd0);
        send_beat(CMD_QUERY, 6'd0, 6'd1, 16'd0);

        for (int n = 0; n < RANDOM_BEATS; n++) begin
            a = pick_node();
            b = ($urandom_range(0, 4) == 0) ? a : pick_node();
            if ($urandom_range(0, 9) < 5)
                send_beat(CMD_WRITE, a, b, pick_weight());
            else
                send_beat(CMD_QUERY, a, b, 16'($urandom));
        end

        @(negedge i_clk);
        start = 1'b0;
        while (graph_sb.entry_q.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);

        if (graph_sb.mismatches == 0 && graph_sb.entry_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/ngl_pkg.sv
hw/rtl/ngl_ctrl.sv
hw/rtl/ngl_dp.sv
hw/rtl/normalized_graph_laplacian.sv
test/normalized_graph_laplacian_test.sv
